// ===== src/dpc_pkg.sv =====
// ============================================================================
// dpc_pkg
// Shared constants, register indexes and types of the detector pixel
// correction pipeline.
// ============================================================================
package dpc_pkg;

    localparam int DPC_PIXEL_BITS = 16;
    localparam int DPC_COORD_BITS = 12;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SATURATION_LEVEL = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BACKGROUND_LEVEL = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BEAMSTOP_RADIUS  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CROSS_HALFWIDTH  = 3'd5;

    // mask state carried down the pipeline with each pixel
    typedef struct packed {
        logic keep;  // own mask bit and external mask combined
        logic hit;   // pixel falls in the beamstop or the cross
    } dpc_flags_t;

endpackage

// ===== src/dpc_if.sv =====
// ============================================================================
// dpc_if
// Handshake channels of the pixel correction block: pixel input beat,
// corrected pixel output beat and configuration write beat.
// ============================================================================
interface dpc_in_if #(
    parameter int PIXEL_BITS = 16,
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] raw_value;
    logic [PIXEL_BITS-1:0] dark_value;
    logic [PIXEL_BITS-1:0] noise_value;
    logic                  valid_in;
    logic                  mask_keep;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;

    modport source (
        output valid, raw_value, dark_value, noise_value, valid_in, mask_keep, col, row,
        input  ready
    );
    modport sink (
        input  valid, raw_value, dark_value, noise_value, valid_in, mask_keep, col, row,
        output ready
    );
endinterface

interface dpc_out_if #(
    parameter int PIXEL_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] value_out;
    logic                  valid_out;

    modport source (
        output valid, value_out, valid_out,
        input  ready
    );
    modport sink (
        input  valid, value_out, valid_out,
        output ready
    );
endinterface

interface dpc_cfg_if #(
    parameter int INDEX_BITS = 3,
    parameter int DATA_BITS  = 16
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== src/dpc_front.sv =====
// ============================================================================
// dpc_front
// First pipeline stage: dark subtraction, noise difference and distances of
// the pixel from the beam centre.
// ============================================================================
module dpc_front #(
    parameter int PIXEL_BITS = 16,
    parameter int COORD_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    output logic                       in_rdy,
    input  logic [PIXEL_BITS-1:0]      raw_value,
    input  logic [PIXEL_BITS-1:0]      dark_value,
    input  logic [PIXEL_BITS-1:0]      noise_value,
    input  logic                       valid_in,
    input  logic                       mask_keep,
    input  logic [COORD_BITS-1:0]      col,
    input  logic [COORD_BITS-1:0]      row,
    input  logic [COORD_BITS-1:0]      center_x,
    input  logic [COORD_BITS-1:0]      center_y,
    output logic                       out_vld,
    input  logic                       out_rdy,
    output logic [PIXEL_BITS-1:0]      value,
    output logic [PIXEL_BITS-1:0]      diff,
    output logic                       below_noise,
    output dpc_pkg::dpc_flags_t        flags,
    output logic [COORD_BITS-1:0]      dx,
    output logic [COORD_BITS-1:0]      dy
);
    import dpc_pkg::*;

    logic                  vld_reg;
    logic                  vld_next;
    logic                  load;
    logic [PIXEL_BITS-1:0] dark_sub;
    logic [PIXEL_BITS-1:0] value_reg;
    logic [PIXEL_BITS-1:0] diff_reg;
    logic                  below_reg;
    dpc_flags_t            flags_reg;
    dpc_flags_t            flags_next;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dx_next;
    logic [COORD_BITS-1:0] dy_reg;
    logic [COORD_BITS-1:0] dy_next;

    assign in_rdy = !vld_reg || out_rdy;
    assign load   = in_vld && in_rdy;

    always_comb
    begin
        dark_sub        = (raw_value > dark_value) ? raw_value - dark_value : '0;
        dx_next         = (col > center_x) ? col - center_x : center_x - col;
        dy_next         = (row > center_y) ? row - center_y : center_y - row;
        flags_next.keep = valid_in && mask_keep;
        flags_next.hit  = 1'b0;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_rdy)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= dark_sub;
            diff_reg  <= dark_sub - noise_value;
            below_reg <= noise_value > dark_sub;
            flags_reg <= flags_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
        end
    end

    assign out_vld     = vld_reg;
    assign value       = value_reg;
    assign diff        = diff_reg;
    assign below_noise = below_reg;
    assign flags       = flags_reg;
    assign dx          = dx_reg;
    assign dy          = dy_reg;

endmodule

// ===== src/dpc_square.sv =====
// ============================================================================
// dpc_square
// Second pipeline stage: squares of the noise excess, of the centre distances
// and of the beamstop radius; cross test.
// ============================================================================
module dpc_square #(
    parameter int PIXEL_BITS = 16,
    parameter int COORD_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_vld,
    output logic                        in_rdy,
    input  logic [PIXEL_BITS-1:0]       value,
    input  logic [PIXEL_BITS-1:0]       diff,
    input  logic                        below_noise,
    input  dpc_pkg::dpc_flags_t         flags,
    input  logic [COORD_BITS-1:0]       dx,
    input  logic [COORD_BITS-1:0]       dy,
    input  logic [COORD_BITS-1:0]       beamstop_radius,
    input  logic [COORD_BITS-1:0]       cross_halfwidth,
    output logic                        out_vld,
    input  logic                        out_rdy,
    output logic [PIXEL_BITS-1:0]       value_q,
    output logic [PIXEL_BITS-1:0]       diff_q,
    output logic                        below_noise_q,
    output dpc_pkg::dpc_flags_t         flags_q,
    output logic [2*PIXEL_BITS-1:0]     diff_sq,
    output logic [2*COORD_BITS-1:0]     dx_sq,
    output logic [2*COORD_BITS-1:0]     dy_sq,
    output logic [2*COORD_BITS-1:0]     radius_sq
);
    import dpc_pkg::*;

    logic                    vld_reg;
    logic                    vld_next;
    logic                    load;
    logic [2*PIXEL_BITS-1:0] diff_wide;
    logic [2*COORD_BITS-1:0] dx_wide;
    logic [2*COORD_BITS-1:0] dy_wide;
    logic [2*COORD_BITS-1:0] radius_wide;
    dpc_flags_t              flags_next;
    logic [PIXEL_BITS-1:0]   value_reg;
    logic [PIXEL_BITS-1:0]   diff_reg;
    logic                    below_reg;
    dpc_flags_t              flags_reg;
    logic [2*PIXEL_BITS-1:0] diff_sq_reg;
    logic [2*COORD_BITS-1:0] dx_sq_reg;
    logic [2*COORD_BITS-1:0] dy_sq_reg;
    logic [2*COORD_BITS-1:0] radius_sq_reg;

    assign in_rdy = !vld_reg || out_rdy;
    assign load   = in_vld && in_rdy;

    always_comb
    begin
        diff_wide       = {{PIXEL_BITS{1'b0}}, diff};
        dx_wide         = {{COORD_BITS{1'b0}}, dx};
        dy_wide         = {{COORD_BITS{1'b0}}, dy};
        radius_wide     = {{COORD_BITS{1'b0}}, beamstop_radius};
        flags_next.keep = flags.keep;
        // min(dx, dy) below the half-width
        flags_next.hit  = flags.hit || (dx < cross_halfwidth) || (dy < cross_halfwidth);
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_rdy)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg     <= value;
            diff_reg      <= diff;
            below_reg     <= below_noise;
            flags_reg     <= flags_next;
            diff_sq_reg   <= diff_wide * diff_wide;
            dx_sq_reg     <= dx_wide * dx_wide;
            dy_sq_reg     <= dy_wide * dy_wide;
            radius_sq_reg <= radius_wide * radius_wide;
        end
    end

    assign out_vld       = vld_reg;
    assign value_q       = value_reg;
    assign diff_q        = diff_reg;
    assign below_noise_q = below_reg;
    assign flags_q       = flags_reg;
    assign diff_sq       = diff_sq_reg;
    assign dx_sq         = dx_sq_reg;
    assign dy_sq         = dy_sq_reg;
    assign radius_sq     = radius_sq_reg;

endmodule

// ===== src/dpc_decide.sv =====
// ============================================================================
// dpc_decide
// Third pipeline stage: noise threshold against the square of the excess
// and beamstop test against the squared radius.
// ============================================================================
module dpc_decide #(
    parameter int PIXEL_BITS = 16,
    parameter int COORD_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_vld,
    output logic                        in_rdy,
    input  logic [PIXEL_BITS-1:0]       value,
    input  logic [PIXEL_BITS-1:0]       diff,
    input  logic                        below_noise,
    input  dpc_pkg::dpc_flags_t         flags,
    input  logic [2*PIXEL_BITS-1:0]     diff_sq,
    input  logic [2*COORD_BITS-1:0]     dx_sq,
    input  logic [2*COORD_BITS-1:0]     dy_sq,
    input  logic [2*COORD_BITS-1:0]     radius_sq,
    output logic                        out_vld,
    input  logic                        out_rdy,
    output logic [PIXEL_BITS-1:0]       value_q,
    output dpc_pkg::dpc_flags_t         flags_q
);
    import dpc_pkg::*;

    logic                    vld_reg;
    logic                    vld_next;
    logic                    load;
    logic                    noise_zero;
    logic [2*COORD_BITS:0]   dist_sq;
    logic [PIXEL_BITS-1:0]   value_next;
    dpc_flags_t              flags_next;
    logic [PIXEL_BITS-1:0]   value_reg;
    dpc_flags_t              flags_reg;

    assign in_rdy = !vld_reg || out_rdy;
    assign load   = in_vld && in_rdy;

    always_comb
    begin
        noise_zero      = below_noise || (diff_sq < {{PIXEL_BITS{1'b0}}, value});
        value_next      = noise_zero ? '0 : diff;
        dist_sq         = {1'b0, dx_sq} + {1'b0, dy_sq};
        flags_next.keep = flags.keep;
        flags_next.hit  = flags.hit || (dist_sq < {1'b0, radius_sq});
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_rdy)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
            flags_reg <= flags_next;
        end
    end

    assign out_vld = vld_reg;
    assign value_q = value_reg;
    assign flags_q = flags_reg;

endmodule

// ===== src/dpc_finish.sv =====
// ============================================================================
// dpc_finish
// Last pipeline stage and output register: saturation, background
// subtraction and final mask bit.
// ============================================================================
module dpc_finish #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_vld,
    output logic                   in_rdy,
    input  logic [PIXEL_BITS-1:0]  value,
    input  dpc_pkg::dpc_flags_t    flags,
    input  logic [PIXEL_BITS-1:0]  saturation_level,
    input  logic [PIXEL_BITS-1:0]  background_level,
    output logic                   out_vld,
    input  logic                   out_rdy,
    output logic [PIXEL_BITS-1:0]  value_out,
    output logic                   valid_out
);
    import dpc_pkg::*;

    logic                  vld_reg;
    logic                  vld_next;
    logic                  load;
    logic                  saturated;
    logic [PIXEL_BITS-1:0] bg_sub;
    logic [PIXEL_BITS-1:0] value_next;
    logic [PIXEL_BITS-1:0] value_reg;
    logic                  valid_reg;

    assign in_rdy = !vld_reg || out_rdy;
    assign load   = in_vld && in_rdy;

    always_comb
    begin
        saturated  = (saturation_level != '0) && (value >= saturation_level);
        bg_sub     = (value > background_level) ? value - background_level : '0;
        value_next = (saturated || flags.hit) ? '0 : bg_sub;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_rdy)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
            valid_reg <= flags.keep && !saturated && !flags.hit;
        end
    end

    assign out_vld   = vld_reg;
    assign value_out = value_reg;
    assign valid_out = valid_reg;

endmodule

// ===== src/detector_pixel_correction.sv =====
// path: an accepted input beat passes the front, square, decide and finish registers to its output beat
// throughput: one pixel per cycle, set by the four-stage pipeline with one
//   multiplier bank in the second stage; each stage holds when its successor is full
// reset: pipeline valid bits and all configuration registers clear to zero;
//   the front stage is empty, so the block can take a pixel right after reset
// ============================================================================
// detector_pixel_correction
// Streaming per-pixel correction: dark, noise, mask, saturation, background
// and beamstop/cross masking, with a configuration write port.
// ============================================================================
module detector_pixel_correction #(
    parameter int PIXEL_BITS = dpc_pkg::DPC_PIXEL_BITS,
    parameter int COORD_BITS = dpc_pkg::DPC_COORD_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    dpc_in_if.sink     pix_in,
    dpc_out_if.source  pix_out,
    dpc_cfg_if.sink    cfg
);
    import dpc_pkg::*;

    logic [PIXEL_BITS-1:0]   saturation_level_reg;
    logic [PIXEL_BITS-1:0]   background_level_reg;
    logic [COORD_BITS-1:0]   center_x_reg;
    logic [COORD_BITS-1:0]   center_y_reg;
    logic [COORD_BITS-1:0]   beamstop_radius_reg;
    logic [COORD_BITS-1:0]   cross_halfwidth_reg;

    logic                    s1_vld;
    logic                    s1_rdy;
    logic [PIXEL_BITS-1:0]   s1_value;
    logic [PIXEL_BITS-1:0]   s1_diff;
    logic                    s1_below;
    dpc_flags_t              s1_flags;
    logic [COORD_BITS-1:0]   s1_dx;
    logic [COORD_BITS-1:0]   s1_dy;

    logic                    s2_vld;
    logic                    s2_rdy;
    logic [PIXEL_BITS-1:0]   s2_value;
    logic [PIXEL_BITS-1:0]   s2_diff;
    logic                    s2_below;
    dpc_flags_t              s2_flags;
    logic [2*PIXEL_BITS-1:0] s2_diff_sq;
    logic [2*COORD_BITS-1:0] s2_dx_sq;
    logic [2*COORD_BITS-1:0] s2_dy_sq;
    logic [2*COORD_BITS-1:0] s2_radius_sq;

    logic                    s3_vld;
    logic                    s3_rdy;
    logic [PIXEL_BITS-1:0]   s3_value;
    dpc_flags_t              s3_flags;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturation_level_reg <= '0;
            background_level_reg <= '0;
            center_x_reg         <= '0;
            center_y_reg         <= '0;
            beamstop_radius_reg  <= '0;
            cross_halfwidth_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SATURATION_LEVEL: saturation_level_reg <= cfg.data[PIXEL_BITS-1:0];
                REG_BACKGROUND_LEVEL: background_level_reg <= cfg.data[PIXEL_BITS-1:0];
                REG_CENTER_X:         center_x_reg         <= cfg.data[COORD_BITS-1:0];
                REG_CENTER_Y:         center_y_reg         <= cfg.data[COORD_BITS-1:0];
                REG_BEAMSTOP_RADIUS:  beamstop_radius_reg  <= cfg.data[COORD_BITS-1:0];
                REG_CROSS_HALFWIDTH:  cross_halfwidth_reg  <= cfg.data[COORD_BITS-1:0];
                default:              ;
            endcase
        end
    end

    dpc_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (pix_in.valid),
        .in_rdy      (pix_in.ready),
        .raw_value   (pix_in.raw_value),
        .dark_value  (pix_in.dark_value),
        .noise_value (pix_in.noise_value),
        .valid_in    (pix_in.valid_in),
        .mask_keep   (pix_in.mask_keep),
        .col         (pix_in.col),
        .row         (pix_in.row),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .out_vld     (s1_vld),
        .out_rdy     (s1_rdy),
        .value       (s1_value),
        .diff        (s1_diff),
        .below_noise (s1_below),
        .flags       (s1_flags),
        .dx          (s1_dx),
        .dy          (s1_dy)
    );

    dpc_square #(
        .PIXEL_BITS (PIXEL_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_square (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_vld          (s1_vld),
        .in_rdy          (s1_rdy),
        .value           (s1_value),
        .diff            (s1_diff),
        .below_noise     (s1_below),
        .flags           (s1_flags),
        .dx              (s1_dx),
        .dy              (s1_dy),
        .beamstop_radius (beamstop_radius_reg),
        .cross_halfwidth (cross_halfwidth_reg),
        .out_vld         (s2_vld),
        .out_rdy         (s2_rdy),
        .value_q         (s2_value),
        .diff_q          (s2_diff),
        .below_noise_q   (s2_below),
        .flags_q         (s2_flags),
        .diff_sq         (s2_diff_sq),
        .dx_sq           (s2_dx_sq),
        .dy_sq           (s2_dy_sq),
        .radius_sq       (s2_radius_sq)
    );

    dpc_decide #(
        .PIXEL_BITS (PIXEL_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (s2_vld),
        .in_rdy      (s2_rdy),
        .value       (s2_value),
        .diff        (s2_diff),
        .below_noise (s2_below),
        .flags       (s2_flags),
        .diff_sq     (s2_diff_sq),
        .dx_sq       (s2_dx_sq),
        .dy_sq       (s2_dy_sq),
        .radius_sq   (s2_radius_sq),
        .out_vld     (s3_vld),
        .out_rdy     (s3_rdy),
        .value_q     (s3_value),
        .flags_q     (s3_flags)
    );

    dpc_finish #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_finish (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_vld           (s3_vld),
        .in_rdy           (s3_rdy),
        .value            (s3_value),
        .flags            (s3_flags),
        .saturation_level (saturation_level_reg),
        .background_level (background_level_reg),
        .out_vld          (pix_out.valid),
        .out_rdy          (pix_out.ready),
        .value_out        (pix_out.value_out),
        .valid_out        (pix_out.valid_out)
    );

endmodule
